// File: rtl/core/pfp_pkg.sv
// Shared types, codes and constant tables for the picture frame parser.
// No dependencies; every other file of the block imports this package.
package pfp_pkg;

  // Byte roles as shown on the result channel
  localparam logic [3:0] ROLE_HEADER    = 4'd0;
  localparam logic [3:0] ROLE_ENCODING  = 4'd1;
  localparam logic [3:0] ROLE_MIME      = 4'd2;
  localparam logic [3:0] ROLE_MIME_NULL = 4'd3;
  localparam logic [3:0] ROLE_TYPE      = 4'd4;
  localparam logic [3:0] ROLE_DESC      = 4'd5;
  localparam logic [3:0] ROLE_DESC_NULL = 4'd6;
  localparam logic [3:0] ROLE_PICTURE   = 4'd7;
  localparam logic [3:0] ROLE_IGNORED   = 4'd8;

  // Frame status codes
  localparam logic [2:0] ST_OK           = 3'd0;
  localparam logic [2:0] ST_TOO_SHORT    = 3'd1;
  localparam logic [2:0] ST_NO_MIME_NULL = 3'd2;
  localparam logic [2:0] ST_BAD_MIME     = 3'd3;
  localparam logic [2:0] ST_NO_TYPE      = 3'd4;
  localparam logic [2:0] ST_NO_DESC_NULL = 3'd5;

  // Register map
  localparam logic REG_HEADER_BYTES = 1'b0;
  localparam logic [3:0] HEADER_BYTES_RESET = 4'd10;

  // Queue between front and back
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = 1;
  localparam int unsigned QCNT_W = 2;

  // Allowed MIME names, zero padded
  localparam int unsigned NUM_MIME = 4;
  localparam int unsigned MIME_MAX = 10;
  localparam logic [7:0] MIME_NAMES [NUM_MIME][MIME_MAX] = '{
    '{"p", "n", "g", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"j", "p", "e", "g", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"i", "m", "a", "g", "e", "/", "p", "n", "g", 8'h00},
    '{"i", "m", "a", "g", "e", "/", "j", "p", "e", "g"}
  };
  localparam logic [3:0] MIME_LENS [NUM_MIME] = '{4'd3, 4'd4, 4'd9, 4'd10};
  localparam logic [7:0] MAX_KIND = 8'd20;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_MIME,
    PH_TYPE,
    PH_DESC,
    PH_PIC,
    PH_IGNORE
  } phase_e;

  // One pre-decoded input beat as it sits in the queue
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       is_zero;
    logic       wide_enc;
    logic [4:0] kind;
  } item_t;

  // One result beat
  typedef struct packed {
    logic [3:0] role;
    logic [7:0] data;
    logic [4:0] kind;
    logic       wide;
    logic [2:0] status;
    logic       last;
  } result_t;

  // Character idx of allowed name c, zero past the end of the table
  function automatic logic [7:0] mime_char(input logic [1:0] c, input logic [3:0] idx);
    logic [7:0] ch;
    ch = 8'h00;
    if (idx < 4'(MIME_MAX)) begin
      ch = MIME_NAMES[c][idx];
    end
    return ch;
  endfunction

endpackage

// File: rtl/core/pfp_front.sv
// Front end: accepts input beats and pre-decodes each byte for the parser.
// Depends on pfp_pkg.
module pfp_front
  import pfp_pkg::*;
(
  input  logic       in_valid_i,
  input  logic [7:0] data_byte_i,
  input  logic       frame_end_i,
  input  logic       q_full_i,
  output logic       in_ready_o,
  output logic       push_o,
  output item_t      item_o
);

  // Accept whenever the queue has room
  assign in_ready_o = !q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  // Classify the byte: zero, wide encoding code, picture type (zero above MAX_KIND)
  always_comb begin
    item_o.data     = data_byte_i;
    item_o.last     = frame_end_i;
    item_o.is_zero  = (data_byte_i == 8'h00);
    item_o.wide_enc = (data_byte_i == 8'h01) || (data_byte_i == 8'h02);
    item_o.kind     = (data_byte_i <= MAX_KIND) ? data_byte_i[4:0] : 5'd0;
  end

endmodule

// File: rtl/core/pfp_queue.sv
// Short register queue between front end and parser back end.
// Depends on pfp_pkg.
module pfp_queue
  import pfp_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  input  logic  pop_i,
  output logic  valid_o,
  output logic  full_o,
  output item_t item_o
);

  item_t             mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;

  assign valid_o = (count_q != '0);
  assign full_o  = (count_q == QCNT_W'(QDEPTH));
  assign item_o  = mem_q[rd_ptr_q];

  // Advance pointers and the fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the entry
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

// File: rtl/core/pfp_back.sv
// Back end: frame parser state machine and registered result stage.
// Depends on pfp_pkg; fed by pfp_queue.
module pfp_back
  import pfp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       q_valid_i,
  input  item_t      item_i,
  input  logic [3:0] header_bytes_i,
  input  logic       out_ready_i,
  output logic       pop_o,
  output logic       out_valid_o,
  output result_t    result_o
);

  phase_e     phase_q, phase_d;
  logic [3:0] hdr_cnt_q, hdr_cnt_d;
  logic [3:0] mime_len_q, mime_len_d;
  logic [3:0] cand_q, cand_d;
  logic       wide_q, wide_d;
  logic       half_q, half_d;
  logic       fhz_q, fhz_d;
  logic [2:0] err_q, err_d;
  logic [4:0] kind_q, kind_d;
  logic       out_valid_q;
  result_t    res_q, res_d;
  logic       mime_ok;

  // Take a beat when the result stage is free or draining
  assign pop_o       = q_valid_i && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign result_o    = res_q;

  // Allowed name that ends with the current length
  always_comb begin
    mime_ok = 1'b0;
    for (int c = 0; c < NUM_MIME; c++) begin
      if (cand_q[c] && (mime_len_q == MIME_LENS[c])) begin
        mime_ok = 1'b1;
      end
    end
  end

  // Next state and result for the beat at the head of the queue
  always_comb begin
    phase_d    = phase_q;
    hdr_cnt_d  = hdr_cnt_q;
    mime_len_d = mime_len_q;
    cand_d     = cand_q;
    wide_d     = wide_q;
    half_d     = half_q;
    fhz_d      = fhz_q;
    err_d      = err_q;
    kind_d     = kind_q;
    res_d.role = ROLE_IGNORED;

    unique case (phase_q)
      PH_HEADER: begin
        if (hdr_cnt_q < header_bytes_i) begin
          res_d.role = ROLE_HEADER;
          hdr_cnt_d  = hdr_cnt_q + 1'b1;
        end else begin
          res_d.role = ROLE_ENCODING;
          wide_d     = item_i.wide_enc;
          phase_d    = PH_MIME;
        end
      end
      PH_MIME: begin
        if (!item_i.is_zero) begin
          res_d.role = ROLE_MIME;
          for (int c = 0; c < NUM_MIME; c++) begin
            if (!((mime_len_q < MIME_LENS[c]) &&
                  (mime_char(2'(c), mime_len_q) == item_i.data))) begin
              cand_d[c] = 1'b0;
            end
          end
          if (mime_len_q != 4'hF) begin
            mime_len_d = mime_len_q + 1'b1;
          end
        end else begin
          res_d.role = ROLE_MIME_NULL;
          if (mime_ok) begin
            phase_d = PH_TYPE;
          end else begin
            err_d   = ST_BAD_MIME;
            phase_d = PH_IGNORE;
          end
        end
      end
      PH_TYPE: begin
        res_d.role = ROLE_TYPE;
        kind_d     = item_i.kind;
        half_d     = 1'b0;
        fhz_d      = 1'b0;
        phase_d    = PH_DESC;
      end
      PH_DESC: begin
        res_d.role = ROLE_DESC;
        if (!wide_q) begin
          if (item_i.is_zero) begin
            res_d.role = ROLE_DESC_NULL;
            phase_d    = PH_PIC;
          end
        end else if (!half_q) begin
          fhz_d  = item_i.is_zero;
          half_d = 1'b1;
        end else begin
          half_d = 1'b0;
          if (fhz_q && item_i.is_zero) begin
            res_d.role = ROLE_DESC_NULL;
            phase_d    = PH_PIC;
          end
        end
      end
      PH_PIC: begin
        res_d.role = ROLE_PICTURE;
      end
      PH_IGNORE: begin
        res_d.role = ROLE_IGNORED;
      end
      default: begin
        res_d.role = ROLE_IGNORED;
      end
    endcase

    // Status reflects the error so far, or where the frame stopped
    res_d.status = err_d;
    if (item_i.last && (err_d == ST_OK)) begin
      unique case (phase_d)
        PH_HEADER: res_d.status = ST_TOO_SHORT;
        PH_MIME:   res_d.status = ST_NO_MIME_NULL;
        PH_TYPE:   res_d.status = ST_NO_TYPE;
        PH_DESC:   res_d.status = ST_NO_DESC_NULL;
        default:   res_d.status = ST_OK;
      endcase
    end
    res_d.data = item_i.data;
    res_d.kind = kind_d;
    res_d.wide = wide_d;
    res_d.last = item_i.last;

    // Restart the parse after the last byte of a frame
    if (item_i.last) begin
      phase_d    = PH_HEADER;
      hdr_cnt_d  = '0;
      mime_len_d = '0;
      cand_d     = '1;
      wide_d     = 1'b0;
      half_d     = 1'b0;
      fhz_d      = 1'b0;
      err_d      = ST_OK;
      kind_d     = '0;
    end
  end

  // Parser state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_HEADER;
      hdr_cnt_q  <= '0;
      mime_len_q <= '0;
      cand_q     <= '1;
      wide_q     <= 1'b0;
      half_q     <= 1'b0;
      fhz_q      <= 1'b0;
      err_q      <= ST_OK;
      kind_q     <= '0;
    end else if (pop_o) begin
      phase_q    <= phase_d;
      hdr_cnt_q  <= hdr_cnt_d;
      mime_len_q <= mime_len_d;
      cand_q     <= cand_d;
      wide_q     <= wide_d;
      half_q     <= half_d;
      fhz_q      <= fhz_d;
      err_q      <= err_d;
      kind_q     <= kind_d;
    end
  end

  // Result stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_o) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result stage payload
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      res_q <= res_d;
    end
  end

endmodule

// File: rtl/core/picture_frame_parser.sv
// Top level of the picture frame parser: config register, front end,
// queue and parser back end. Depends on pfp_pkg, pfp_front, pfp_queue, pfp_back.
//
//   Port group   Direction  Handshake            Content
//   input beat   in         in_valid/in_ready    data_byte, frame_end
//   result beat  out        out_valid/out_ready  role, data, kind, wide, status, last
//   config       in         APB psel/penable     header_bytes at byte address 0
//
// One beat per cycle sustained while out_ready stays high; an accepted beat passes the
// queue entry, then the parser update into the result register, before it leaves.
// The two-entry queue lets input acceptance continue while a result waits; input
// ready drops only once the queue holds two beats.
// Reset clears the parser, the queue and the result stage; header_bytes returns to 10.
module picture_frame_parser
  import pfp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        frame_end_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [3:0]  byte_role_o,
  output logic [7:0]  data_out_o,
  output logic [4:0]  picture_kind_o,
  output logic        wide_text_o,
  output logic [2:0]  frame_status_o,
  output logic        last_out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [3:0] header_bytes_q;
  logic       q_full;
  logic       q_valid;
  logic       push;
  logic       pop;
  item_t      fe_item;
  item_t      q_item;
  result_t    result;
  logic       reg_sel;

  // Config register
  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == REG_HEADER_BYTES);
  assign prdata  = reg_sel ? {28'd0, header_bytes_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_bytes_q <= HEADER_BYTES_RESET;
    end else if (psel && penable && pwrite && reg_sel) begin
      header_bytes_q <= pwdata[3:0];
    end
  end

  pfp_front u_front (
    .in_valid_i  (in_valid_i),
    .data_byte_i (data_byte_i),
    .frame_end_i (frame_end_i),
    .q_full_i    (q_full),
    .in_ready_o  (in_ready_o),
    .push_o      (push),
    .item_o      (fe_item)
  );

  pfp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (fe_item),
    .pop_i   (pop),
    .valid_o (q_valid),
    .full_o  (q_full),
    .item_o  (q_item)
  );

  pfp_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .item_i         (q_item),
    .header_bytes_i (header_bytes_q),
    .out_ready_i    (out_ready_i),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .result_o       (result)
  );

  // Unpack the result beat
  assign byte_role_o    = result.role;
  assign data_out_o     = result.data;
  assign picture_kind_o = result.kind;
  assign wide_text_o    = result.wide;
  assign frame_status_o = result.status;
  assign last_out_o     = result.last;

endmodule

// File: rtl/core/pfp_checker.sv
// Port-level checks on the picture frame parser result channel, bound to the top.
// Depends on pfp_pkg and picture_frame_parser.
module pfp_checker
  import pfp_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [3:0]  byte_role_o,
  input logic [7:0]  data_out_o,
  input logic [4:0]  picture_kind_o,
  input logic [2:0]  frame_status_o,
  input logic        last_out_o
);

  // Hold a stalled result beat
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(data_out_o) &&
      $stable(byte_role_o) && $stable(frame_status_o) && $stable(last_out_o))
    else $error("result beat changed while stalled");

  // A frame that stops inside the header is too short
  a_hdr_short: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_out_o && (byte_role_o == ROLE_HEADER) |->
      (frame_status_o == ST_TOO_SHORT))
    else $error("header end without short status");

  // Ignored bytes only follow a rejected MIME name
  a_ignored_bad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (byte_role_o == ROLE_IGNORED) |-> (frame_status_o == ST_BAD_MIME))
    else $error("ignored byte without bad mime status");

  // Picture data implies a clean frame so far and a picture type within the limit
  a_pic_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (byte_role_o == ROLE_PICTURE) |->
      (frame_status_o == ST_OK) && (picture_kind_o <= MAX_KIND[4:0]))
    else $error("picture byte with error status");

endmodule

bind picture_frame_parser pfp_checker u_pfp_checker (.*);

// File: tb/sv/tb_picture_frame_parser.sv
`timescale 1ns / 1ps
// Self-checking testbench for picture_frame_parser: frames of attached-picture bytes
// in, tagged bytes out. Depends on pfp_pkg and the picture_frame_parser RTL.

// Tracks the parse of each frame and holds the tagged beats still due from the block
class frame_tracker;
  pfp_pkg::result_t due_beats[$];
  int               fails;
  int               beats_seen;
  string            mime_ok[4];
  logic [3:0]       hdr_len;
  pfp_pkg::phase_e  phase;
  logic [3:0]       hdr_seen;
  logic [3:0]       mime_len;
  logic [3:0]       cands;
  logic             wide;
  logic             half;
  logic             first_zero;
  logic [2:0]       err;
  logic [4:0]       kind;

  function new();
    mime_ok[0] = "png";
    mime_ok[1] = "jpeg";
    mime_ok[2] = "image/png";
    mime_ok[3] = "image/jpeg";
    fails      = 0;
    beats_seen = 0;
    hdr_len    = 4'd10;
    restart();
  endfunction

  // Clear per-frame state; also done after every last byte
  function void restart();
    phase      = pfp_pkg::PH_HEADER;
    hdr_seen   = '0;
    mime_len   = '0;
    cands      = 4'hF;
    wide       = 1'b0;
    half       = 1'b0;
    first_zero = 1'b0;
    err        = pfp_pkg::ST_OK;
    kind       = '0;
  endfunction

  function void set_header(logic [3:0] v);
    hdr_len = v;
  endfunction

  function int pending();
    return due_beats.size();
  endfunction

  function void report(string msg);
    fails++;
    if (fails <= 10) begin
      $display("%s", msg);
    end
  endfunction

  function void check_field(string fname, int want, int got);
    if (want != got) begin
      report($sformatf("beat %0d %s: expected %0d, got %0d", beats_seen, fname, want, got));
    end
  endfunction

  // Advance the parse by one accepted byte and queue the beat it must produce
  function void take_byte(logic [7:0] b, logic last);
    pfp_pkg::result_t r;
    logic             ok;
    int               c;
    r.role = pfp_pkg::ROLE_IGNORED;
    case (phase)
      pfp_pkg::PH_HEADER: begin
        if (hdr_seen < hdr_len) begin
          r.role   = pfp_pkg::ROLE_HEADER;
          hdr_seen = hdr_seen + 4'd1;
        end else begin
          r.role = pfp_pkg::ROLE_ENCODING;
          wide   = (b == 8'd1 || b == 8'd2);
          phase  = pfp_pkg::PH_MIME;
        end
      end
      pfp_pkg::PH_MIME: begin
        if (b != 8'd0) begin
          r.role = pfp_pkg::ROLE_MIME;
          // drop every name that no longer fits the string so far
          for (c = 0; c < 4; c++) begin
            if (!(mime_len < mime_ok[c].len() && mime_ok[c][mime_len] == b)) begin
              cands[c] = 1'b0;
            end
          end
          if (mime_len != 4'd15) begin
            mime_len = mime_len + 4'd1;
          end
        end else begin
          r.role = pfp_pkg::ROLE_MIME_NULL;
          ok = 1'b0;
          for (c = 0; c < 4; c++) begin
            if (cands[c] && mime_len == mime_ok[c].len()) begin
              ok = 1'b1;
            end
          end
          if (ok) begin
            phase = pfp_pkg::PH_TYPE;
          end else begin
            err   = pfp_pkg::ST_BAD_MIME;
            phase = pfp_pkg::PH_IGNORE;
          end
        end
      end
      pfp_pkg::PH_TYPE: begin
        r.role     = pfp_pkg::ROLE_TYPE;
        kind       = (b <= 8'd20) ? b[4:0] : 5'd0;
        half       = 1'b0;
        first_zero = 1'b0;
        phase      = pfp_pkg::PH_DESC;
      end
      pfp_pkg::PH_DESC: begin
        r.role = pfp_pkg::ROLE_DESC;
        if (!wide) begin
          if (b == 8'd0) begin
            r.role = pfp_pkg::ROLE_DESC_NULL;
            phase  = pfp_pkg::PH_PIC;
          end
        end else if (!half) begin
          first_zero = (b == 8'd0);
          half       = 1'b1;
        end else begin
          // a terminator only on an aligned zero pair
          half = 1'b0;
          if (first_zero && b == 8'd0) begin
            r.role = pfp_pkg::ROLE_DESC_NULL;
            phase  = pfp_pkg::PH_PIC;
          end
        end
      end
      pfp_pkg::PH_PIC: begin
        r.role = pfp_pkg::ROLE_PICTURE;
      end
      default: begin
        r.role = pfp_pkg::ROLE_IGNORED;
      end
    endcase

    // status is final on the last byte: name the phase the frame stopped in
    r.status = err;
    if (last && err == pfp_pkg::ST_OK) begin
      case (phase)
        pfp_pkg::PH_HEADER: r.status = pfp_pkg::ST_TOO_SHORT;
        pfp_pkg::PH_MIME:   r.status = pfp_pkg::ST_NO_MIME_NULL;
        pfp_pkg::PH_TYPE:   r.status = pfp_pkg::ST_NO_TYPE;
        pfp_pkg::PH_DESC:   r.status = pfp_pkg::ST_NO_DESC_NULL;
        default:            r.status = pfp_pkg::ST_OK;
      endcase
    end
    r.data = b;
    r.kind = kind;
    r.wide = wide;
    r.last = last;
    due_beats.push_back(r);
    if (last) begin
      restart();
    end
  endfunction

  // Compare one result beat with the oldest one due
  function void match_beat(pfp_pkg::result_t got);
    pfp_pkg::result_t want;
    beats_seen++;
    if (due_beats.size() == 0) begin
      report($sformatf("beat %0d: unexpected result, data %0d role %0d",
                       beats_seen, got.data, got.role));
      return;
    end
    want = due_beats.pop_front();
    check_field("byte_role", want.role, got.role);
    check_field("data_out", want.data, got.data);
    check_field("picture_kind", want.kind, got.kind);
    check_field("wide_text", want.wide, got.wide);
    check_field("frame_status", want.status, got.status);
    check_field("last_out", want.last, got.last);
  endfunction
endclass

module tb_picture_frame_parser;
  import pfp_pkg::*;

  localparam int         CYCLE_LIMIT = 400000;
  localparam logic [2:0] HDR_ADDR    = 3'(4 * int'(REG_HEADER_BYTES));

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  data_byte_i;
  logic        frame_end_i;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [3:0]  byte_role_o;
  logic [7:0]  data_out_o;
  logic [4:0]  picture_kind_o;
  logic        wide_text_o;
  logic [2:0]  frame_status_o;
  logic        last_out_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  frame_tracker     tracker;
  result_t          seen;
  logic [7:0]       frame_q[$];
  string            mime_ok[4];
  logic [3:0]       phase_hdr[5];
  int               burst_left;
  int               rx_mode;
  int               rx_left = 0;
  int               rx_run = 0;
  logic             rx_hold = 1'b1;

  picture_frame_parser dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .data_byte_i    (data_byte_i),
    .frame_end_i    (frame_end_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .byte_role_o    (byte_role_o),
    .data_out_o     (data_out_o),
    .picture_kind_o (picture_kind_o),
    .wide_text_o    (wide_text_o),
    .frame_status_o (frame_status_o),
    .last_out_o     (last_out_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Stall the result channel: always ready, coin flips, or long stall runs
  always @(negedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 2);
      rx_left = $urandom_range(16, 96);
    end
    rx_left--;
    case (rx_mode)
      0: out_ready_i <= 1'b1;
      1: out_ready_i <= 1'($urandom_range(0, 1));
      default: begin
        if (rx_run == 0) begin
          rx_hold = !rx_hold;
          rx_run  = rx_hold ? $urandom_range(1, 6) : $urandom_range(1, 12);
        end
        rx_run--;
        out_ready_i <= rx_hold;
      end
    endcase
  end

  // Check every result beat taken at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      seen.role   = byte_role_o;
      seen.data   = data_out_o;
      seen.kind   = picture_kind_o;
      seen.wide   = wide_text_o;
      seen.status = frame_status_o;
      seen.last   = last_out_o;
      tracker.match_beat(seen);
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("TEST FAILED");
    $finish;
  end

  // Send one beat; called at a falling edge, returns at a falling edge
  task automatic push_beat(input logic [7:0] b, input logic last);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 40);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    frame_end_i <= last;
    do @(posedge clk_i); while (!in_ready_o);
    tracker.take_byte(b, last);
    @(negedge clk_i);
  endtask

  task automatic send_frame();
    foreach (frame_q[i]) begin
      push_beat(frame_q[i], i == frame_q.size() - 1);
    end
  endtask

  // Hold the sender until every due beat has come out
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (tracker.pending() != 0);
    @(negedge clk_i);
  endtask

  task automatic reg_check(input logic [3:0] want);
    logic [31:0] got;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= HDR_ADDR;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    got = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    tracker.check_field("header_bytes readback", want, got);
  endtask

  task automatic reg_write(input logic [3:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= HDR_ADDR;
    pwdata  <= 32'(v);
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    tracker.set_header(v);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    reg_check(v);
  endtask

  // Random frames: most follow the frame layout with random content, some cut short, some noise
  task automatic run_phase(input logic [3:0] hb, input int quota);
    int         sent;
    int         shape;
    int         n;
    int         pick;
    int         cut;
    logic [7:0] lo;
    logic [7:0] hi;
    logic [7:0] enc;
    string      nm;
    sent = 0;
    while (sent < quota) begin
      frame_q.delete();
      shape = $urandom_range(0, 99);
      if (shape < 8) begin
        n = $urandom_range(1, 24);
        repeat (n) frame_q.push_back(8'($urandom_range(0, 255)));
      end else begin
        repeat (hb) frame_q.push_back(8'($urandom_range(0, 255)));
        pick = $urandom_range(0, 3);
        enc  = (pick == 3) ? 8'($urandom_range(0, 255)) : 8'(pick);
        frame_q.push_back(enc);

        // MIME string: allowed name, or a near miss of one
        nm   = mime_ok[$urandom_range(0, 3)];
        n    = 0;
        pick = $urandom_range(0, 11);
        case (pick)
          7:  nm = nm.substr(0, $urandom_range(0, nm.len() - 1) - 1);
          8:  nm[$urandom_range(0, nm.len() - 1)] = 8'($urandom_range(1, 255));
          9:  n = $urandom_range(1, 5);
          10: n = $urandom_range(6, 14);
          11: nm = "";
          default: n = 0;
        endcase
        for (int i = 0; i < nm.len(); i++) begin
          frame_q.push_back(nm[i]);
        end
        repeat (n) frame_q.push_back(8'($urandom_range(1, 255)));
        frame_q.push_back(8'h00);

        frame_q.push_back(($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 25))
                                                     : 8'($urandom_range(0, 255)));

        // description and its terminator
        n = $urandom_range(0, 5);
        if (enc == 8'd1 || enc == 8'd2) begin
          repeat (n) begin
            pick = $urandom_range(0, 3);
            lo   = 8'($urandom_range(0, 255));
            hi   = 8'($urandom_range(0, 255));
            if (pick == 0) lo = 8'h00;
            if (pick == 1) hi = 8'h00;
            if (lo == 8'h00 && hi == 8'h00) hi = 8'($urandom_range(1, 255));
            frame_q.push_back(lo);
            frame_q.push_back(hi);
          end
          frame_q.push_back(8'h00);
          frame_q.push_back(8'h00);
        end else begin
          repeat (n) frame_q.push_back(8'($urandom_range(1, 255)));
          frame_q.push_back(8'h00);
        end

        n = $urandom_range(0, 12);
        repeat (n) frame_q.push_back(8'($urandom_range(0, 255)));

        // cut some frames short at any byte
        if (shape < 30) begin
          cut = $urandom_range(1, frame_q.size());
          while (frame_q.size() > cut) void'(frame_q.pop_back());
        end
      end
      send_frame();
      sent += frame_q.size();
      if ($urandom_range(0, 11) == 0) begin
        wait_drained();
      end
    end
  endtask

  initial begin
    tracker      = new();
    mime_ok[0]   = "png";
    mime_ok[1]   = "jpeg";
    mime_ok[2]   = "image/png";
    mime_ok[3]   = "image/jpeg";
    phase_hdr[0] = 4'd10;
    phase_hdr[1] = 4'd7;
    phase_hdr[2] = 4'd6;
    phase_hdr[3] = 4'd9;
    phase_hdr[4] = 4'd8;
    burst_left   = 0;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    data_byte_i  = 8'h00;
    frame_end_i  = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    reg_check(4'd10);
    reg_write(4'd6);

    // frame ends inside the header
    frame_q = '{8'h00, 8'hFF};
    send_frame();
    // frame ends on the encoding byte, 16-bit mode selected
    frame_q = '{8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h01};
    send_frame();
    // "png", type above the limit, empty description and empty picture data
    frame_q = '{8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'h00,
                8'h70, 8'h6E, 8'h67, 8'h00, 8'hFF, 8'h00};
    send_frame();
    wait_drained();

    foreach (phase_hdr[k]) begin
      reg_write(phase_hdr[k]);
      run_phase(phase_hdr[k], 380);
      wait_drained();
    end

    // let any stray beat show up before the verdict
    repeat (12) @(posedge clk_i);
    if (tracker.pending() != 0) begin
      tracker.report($sformatf("%0d result beats never arrived", tracker.pending()));
    end
    if (tracker.fails == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/core/pfp_pkg.sv
rtl/core/pfp_front.sv
rtl/core/pfp_queue.sv
rtl/core/pfp_back.sv
rtl/core/picture_frame_parser.sv
rtl/core/pfp_checker.sv
tb/sv/tb_picture_frame_parser.sv
